[src/dtt_pkg.sv]
// Shared types and codes for the deadline timer table.
package dtt_pkg;

  localparam logic [2:0] ACT_ADD     = 3'd0;
  localparam logic [2:0] ACT_CANCEL  = 3'd1;
  localparam logic [2:0] ACT_REFRESH = 3'd2;
  localparam logic [2:0] ACT_RESET   = 3'd3;
  localparam logic [2:0] ACT_QUERY   = 3'd4;
  localparam logic [2:0] ACT_EXPIRE  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 72;
  localparam logic [31:0] ROLL_WIN_RESET = 32'd3600000;

  typedef struct packed {
    logic [2:0]  act;
    logic [4:0]  tid;
    logic        id_ok;
    logic [31:0] period;
    logic        rep;
    logic        fnow;
    logic [63:0] now;
  } cmd_t;

endpackage

[src/deadline_timer_table_top.sv]
// Top level of the deadline timer table.
// Table of TIMER_SLOTS software-style timers ordered by deadline, then handle.
// Commands enter on the slave stream (tuser = action) into a two-beat command
// queue, so one command can wait while another runs; results leave through a
// registered master stream, tlast on the final beat of each command. Cost per
// command is set by the single-port timer store, read one slot per cycle:
// cancel, unknown actions and a full-table add need no read; refresh and reset
// read their slot first; add, reset-with-change and query do one scan of all
// slots; expire does one scan plus one scan per due timer. There is no clearing
// pass after reset: only the active bits and control registers are cleared,
// not the timer store. rollover_window is written through cfg_we/cfg_wdata by
// the user only while idle; the block itself does not enforce this.
module deadline_timer_table_top #(
  parameter int TIMER_SLOTS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [31:0]                      cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // timer_id[4:0], period[36:5], repeat_req[37], rebase_now[38], now_ms[102:39]
  input  logic [dtt_pkg::IN_DATA_W-1:0]    s_tdata,
  // action
  input  logic [2:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_id[4:0], wait_ms[68:5], front_notice[69], pending[70]
  output logic [dtt_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status
  output logic [1:0]                       m_tuser,
  output logic                             m_tlast
);
  import dtt_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  dtt_front #(.TIMER_SLOTS(TIMER_SLOTS)) u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .cmd_valid, .cmd_ready, .cmd
  );

  dtt_back #(.TIMER_SLOTS(TIMER_SLOTS)) u_back (
    .clk, .rst, .cfg_we, .cfg_wdata, .cmd_valid, .cmd_ready, .cmd,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

endmodule

[src/dtt_front.sv]
// Front end: accepts beats, decodes them and queues commands for the back end.
module dtt_front #(
  parameter int TIMER_SLOTS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dtt_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [2:0]                       s_tuser,
  output logic                             cmd_valid,
  input  logic                             cmd_ready,
  output dtt_pkg::cmd_t                    cmd
);
  import dtt_pkg::*;

  cmd_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec.act    = s_tuser;
    dec.tid    = s_tdata[4:0];
    dec.id_ok  = {2'b00, s_tdata[4:0]} < 7'(TIMER_SLOTS);
    dec.period = s_tdata[36:5];
    dec.rep    = s_tdata[37];
    dec.fnow   = s_tdata[38];
    dec.now    = s_tdata[102:39];
  end

  assign s_tready  = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q[wp] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

[src/dtt_back.sv]
// Back end: timer storage, slot scans and result sequencing.
module dtt_back #(
  parameter int TIMER_SLOTS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [31:0]                      cfg_wdata,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  dtt_pkg::cmd_t                    cmd,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dtt_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [1:0]                       m_tuser,
  output logic                             m_tlast
);
  import dtt_pkg::*;

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = SW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_RD1, S_RD2, S_ACT, S_ACT2, S_SCAN, S_POST, S_EMIT
  } state_t;

  state_t                 state;
  cmd_t                   cmd_r;
  logic [TIMER_SLOTS-1:0] active, due, rpv;
  logic                   notified;
  logic [63:0]            prev_time, diff, start;
  logic [31:0]            window;
  logic                   roll, scan_due;
  logic [CW-1:0]          iss;
  logic                   v1, v2;
  logic [SW-1:0]          i1, i2, best_i, tgt;
  logic                   best_v, best_rp;
  logic [63:0]            best_dl;
  logic [31:0]            best_iv;
  logic [1:0]             o_status;
  logic [4:0]             o_id;
  logic [63:0]            o_wait;
  logic                   o_fn, o_last;

  logic [63:0]            dl_mem [TIMER_SLOTS];
  logic [31:0]            iv_mem [TIMER_SLOTS];
  logic                   rp_mem [TIMER_SLOTS];
  logic [SW-1:0]          rd_addr;
  logic [63:0]            rd_dl;
  logic [31:0]            rd_iv;
  logic                   rd_rp;

  logic                   free_found;
  logic [SW-1:0]          free_idx, in_t, cur_t;
  logic [TIMER_SLOTS-1:0] best_oh;
  logic                   cand;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
    best_oh         = '0;
    best_oh[best_i] = 1'b1;
    in_t  = cmd.id_ok ? SW'(cmd.tid) : '0;
    cur_t = cmd_r.id_ok ? SW'(cmd_r.tid) : '0;
    cand  = scan_due ? due[i2] : active[i2];
  end

  assign cmd_ready = (state == S_IDLE);
  assign m_tvalid  = (state == S_EMIT);
  assign m_tuser   = o_status;
  assign m_tlast   = o_last;
  assign m_tdata   = {1'b0, |active, o_fn, o_wait, o_id};

  always_ff @(posedge clk) begin
    rd_dl <= dl_mem[rd_addr];
    rd_iv <= iv_mem[rd_addr];
    rd_rp <= rp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      notified  <= 1'b0;
      prev_time <= '0;
      window    <= ROLL_WIN_RESET;
      scan_due  <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
    end else begin
      if (cfg_we) window <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r    <= cmd;
            scan_due <= 1'b0;
            o_status <= ST_OK;
            o_id     <= '0;
            o_wait   <= '0;
            o_fn     <= 1'b0;
            o_last   <= 1'b1;
            rd_addr  <= in_t;
            iss      <= '0;
            v1       <= 1'b0;
            v2       <= 1'b0;
            best_v   <= 1'b0;
            unique case (cmd.act) inside
              ACT_ADD: begin
                if (free_found) begin
                  active[free_idx] <= 1'b1;
                  rp_mem[free_idx] <= cmd.rep;
                  iv_mem[free_idx] <= cmd.period;
                  dl_mem[free_idx] <= cmd.now + {32'd0, cmd.period};
                  tgt              <= free_idx;
                  o_id             <= 5'(free_idx);
                  state            <= S_SCAN;
                end else begin
                  o_status <= ST_FULL;
                  state    <= S_EMIT;
                end
              end
              ACT_CANCEL: begin
                if (cmd.id_ok && active[in_t]) active[in_t] <= 1'b0;
                else o_status <= ST_REFUSED;
                state <= S_EMIT;
              end
              ACT_REFRESH, ACT_RESET: state <= S_RD1;
              ACT_QUERY: begin
                notified <= 1'b0;
                state    <= S_SCAN;
              end
              ACT_EXPIRE: begin
                diff  <= prev_time - {32'd0, window};
                state <= S_PREP;
              end
              default: begin
                o_status <= ST_REFUSED;
                state    <= S_EMIT;
              end
            endcase
          end
        end
        S_PREP: begin
          roll  <= (cmd_r.now < prev_time) && (cmd_r.now < diff);
          due   <= '0;
          state <= S_SCAN;
        end
        S_RD1: state <= S_RD2;
        S_RD2: state <= S_ACT;
        S_ACT: begin
          if (cmd_r.act == ACT_REFRESH) begin
            if (cmd_r.id_ok && active[cur_t]) dl_mem[cur_t] <= cmd_r.now + {32'd0, rd_iv};
            else o_status <= ST_REFUSED;
            state <= S_EMIT;
          end else if (cmd_r.id_ok && cmd_r.period == rd_iv && !cmd_r.fnow) begin
            state <= S_EMIT;
          end else if (cmd_r.id_ok && active[cur_t]) begin
            start <= cmd_r.fnow ? cmd_r.now : rd_dl - {32'd0, rd_iv};
            state <= S_ACT2;
          end else begin
            o_status <= ST_REFUSED;
            state    <= S_EMIT;
          end
        end
        S_ACT2: begin
          dl_mem[cur_t] <= start + {32'd0, cmd_r.period};
          iv_mem[cur_t] <= cmd_r.period;
          tgt           <= cur_t;
          state         <= S_SCAN;
        end
        S_SCAN: begin
          // read pipeline: issue -> v1 -> v2 (data in rd_*)
          if (iss < CW'(TIMER_SLOTS)) begin
            rd_addr <= iss[SW-1:0];
            iss     <= iss + 1'b1;
            v1      <= 1'b1;
            i1      <= iss[SW-1:0];
          end else begin
            v1 <= 1'b0;
          end
          v2 <= v1;
          i2 <= i1;
          if (v2) begin
            if (cand && (!best_v || rd_dl < best_dl)) begin
              best_v  <= 1'b1;
              best_i  <= i2;
              best_dl <= rd_dl;
              best_iv <= rd_iv;
              best_rp <= rd_rp;
            end
            if (cmd_r.act == ACT_EXPIRE && !scan_due) begin
              due[i2] <= active[i2] && (roll || rd_dl <= cmd_r.now);
              rpv[i2] <= rd_rp;
            end
          end
          if (!(iss < CW'(TIMER_SLOTS)) && !v1 && !v2) state <= S_POST;
        end
        S_POST: begin
          unique case (cmd_r.act) inside
            ACT_ADD, ACT_RESET: begin
              if (best_v && best_i == tgt && !notified) begin
                o_fn     <= 1'b1;
                notified <= 1'b1;
              end
              state <= S_EMIT;
            end
            ACT_QUERY: begin
              if (!best_v) o_wait <= '1;
              else if (cmd_r.now >= best_dl) o_wait <= '0;
              else o_wait <= best_dl - cmd_r.now;
              state <= S_EMIT;
            end
            default: begin
              if (scan_due) begin
                due[best_i] <= 1'b0;
                if (best_rp) dl_mem[best_i] <= cmd_r.now + {32'd0, best_iv};
                o_id   <= 5'(best_i);
                o_last <= ~|(due & ~best_oh);
                state  <= S_EMIT;
              end else if (!best_v) begin
                o_status <= ST_REFUSED;
                state    <= S_EMIT;
              end else begin
                prev_time <= cmd_r.now;
                if (!roll && best_dl > cmd_r.now) begin
                  o_status <= ST_REFUSED;
                  state    <= S_EMIT;
                end else begin
                  active   <= active & ~(due & ~rpv);
                  scan_due <= 1'b1;
                  iss      <= '0;
                  best_v   <= 1'b0;
                  state    <= S_SCAN;
                end
              end
            end
          endcase
        end
        S_EMIT: begin
          if (m_tready) begin
            if (cmd_r.act == ACT_EXPIRE && scan_due && !o_last) begin
              iss    <= '0;
              best_v <= 1'b0;
              state  <= S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/dtt_checker.sv]
// Port-level checks for the deadline timer table, bound to the top level.
module dtt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [dtt_pkg::OUT_DATA_W-1:0]   m_tdata,
  input logic [1:0]                       m_tuser,
  input logic                             m_tlast
);
  import dtt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3)
    else $error("bad status code");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> m_tdata[4:0] == 5'd0 && m_tlast && !m_tdata[69])
    else $error("full answer malformed");

  a_notice: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[69] |-> m_tuser == ST_OK && m_tlast && m_tdata[70])
    else $error("front notice without armed timer");

endmodule

bind deadline_timer_table_top dtt_checker u_chk (.*);
